### rtl/flp3_pkg.sv
// ----------------------------------------------------------------------------
// flp3_pkg
// Shared types, constants and coefficient tables of the three-band low-pass
// FIR filter.
// ----------------------------------------------------------------------------
package flp3_pkg;

  localparam int TAPS   = 17;
  localparam int IDX_W  = 5;
  localparam int SMP_W  = 16;
  localparam int COEF_W = 10;
  localparam int PROD_W = SMP_W + COEF_W;
  localparam int ACC_W  = 27;
  localparam int SET_W  = 2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAPS - 1);

  localparam logic [SET_W-1:0] BAND_NARROW = 2'd0;
  localparam logic [SET_W-1:0] BAND_MIDDLE = 2'd1;
  localparam logic [SET_W-1:0] BAND_WIDE   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic mul_en;
    logic acc_en;
  } mac_ctrl_t;

  typedef logic signed [COEF_W-1:0] coef_t;

  localparam coef_t NARROW_COEF [TAPS] = '{
    -10'sd7, -10'sd18, -10'sd15, 10'sd11, 10'sd56, 10'sd116, 10'sd177, 10'sd223,
    10'sd240, 10'sd223, 10'sd177, 10'sd116, 10'sd56, 10'sd11, -10'sd15, -10'sd18,
    -10'sd7
  };

  localparam coef_t MIDDLE_COEF [TAPS] = '{
    10'sd0, -10'sd18, -10'sd38, -10'sd39, 10'sd0, 10'sd83, 10'sd191, 10'sd284,
    10'sd320, 10'sd284, 10'sd191, 10'sd83, 10'sd0, -10'sd39, -10'sd38, -10'sd18,
    10'sd0
  };

  localparam coef_t WIDE_COEF [TAPS] = '{
    10'sd6, 10'sd20, 10'sd7, -10'sd42, -10'sd74, -10'sd12, 10'sd159, 10'sd353,
    10'sd440, 10'sd353, 10'sd159, -10'sd12, -10'sd74, -10'sd42, 10'sd7, 10'sd20,
    10'sd6
  };

  // Unused selector code falls back to the wide set
  function automatic coef_t coef(input logic [SET_W-1:0] set, input logic [IDX_W-1:0] k);
    coef_t c;
    case (set)
      BAND_NARROW: c = NARROW_COEF[k];
      BAND_MIDDLE: c = MIDDLE_COEF[k];
      default:     c = WIDE_COEF[k];
    endcase
    return c;
  endfunction

endpackage

### rtl/flp3_delay.sv
// ----------------------------------------------------------------------------
// flp3_delay
// Circular delay line of the last TAPS samples with a write pointer that
// steps back by one after each item.
// ----------------------------------------------------------------------------
module flp3_delay
  import flp3_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic signed [SMP_W-1:0] wr_data,
  input  logic                    step_en,
  input  logic [IDX_W-1:0]        rd_addr,
  output logic signed [SMP_W-1:0] rd_data,
  output logic [IDX_W-1:0]        slot
);

  logic signed [SMP_W-1:0] line [TAPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAPS; i++) begin
        line[i] <= '0;
      end
    end else if (wr_en) begin
      line[slot] <= wr_data;
    end
  end

  // step back, wrapping from the first slot to the last
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (step_en) begin
      slot <= (slot == '0) ? LAST_IDX : slot - IDX_W'(1);
    end
  end

  assign rd_data = line[rd_addr];

endmodule

### rtl/flp3_mac.sv
// ----------------------------------------------------------------------------
// flp3_mac
// Shared multiply-accumulate unit: one registered product per cycle while
// mul_en is set, added into the accumulator on the following cycle by acc_en.
// ----------------------------------------------------------------------------
module flp3_mac
  import flp3_pkg::*;
(
  input  logic                     clk,
  input  mac_ctrl_t                ctrl,
  input  logic signed [SMP_W-1:0]  smp,
  input  coef_t                    cf,
  output logic signed [ACC_W-1:0]  acc
);

  logic signed [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= smp * cf;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc + ACC_W'(prod);
    end
  end

endmodule

### rtl/fir_lowpass_17tap_three_band.sv
// ----------------------------------------------------------------------------
// fir_lowpass_17tap_three_band
// 17-tap low-pass FIR with three fixed coefficient sets, one shared MAC.
// ----------------------------------------------------------------------------
// Operation: the shared multiply-accumulate takes one tap per cycle in ST_RUN,
//   then adds the last product in ST_DRAIN; ST_DONE loads filtered_out once
//   the output register is free. in_stall holds new items off outside ST_IDLE.
// A finished result waits in the output register while the next item computes.
// Reset (rst, synchronous): delay line, pointers, band_sel and out_valid cleared.
module fir_lowpass_17tap_three_band
  import flp3_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [SMP_W-1:0] sample_in,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [ACC_W-1:0] filtered_out,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [SET_W-1:0]        band_select
);

  state_t state, state_next;
  logic [IDX_W-1:0] k, k_next;
  logic [IDX_W-1:0] pos, pos_next;
  logic [SET_W-1:0] band_sel;
  logic [IDX_W-1:0] slot;
  logic signed [SMP_W-1:0] rd_data;
  logic signed [ACC_W-1:0] acc;
  mac_ctrl_t mac_ctrl;
  logic accept, out_free, load_out, step_en;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_sel <= BAND_NARROW;
    end else if (cfg_valid && cfg_ready) begin
      band_sel <= band_select;
    end
  end

  flp3_delay u_delay (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (sample_in),
    .step_en (step_en),
    .rd_addr (pos),
    .rd_data (rd_data),
    .slot    (slot)
  );

  flp3_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .smp  (rd_data),
    .cf   (coef(band_sel, k)),
    .acc  (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
      pos   <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      pos   <= pos_next;
    end
  end

  always_comb begin
    state_next      = state;
    k_next          = k;
    pos_next        = pos;
    mac_ctrl.clr    = 1'b0;
    mac_ctrl.mul_en = 1'b0;
    mac_ctrl.acc_en = 1'b0;
    load_out        = 1'b0;
    step_en         = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          mac_ctrl.clr = 1'b1;
          k_next       = '0;
          pos_next     = slot;
          state_next   = ST_RUN;
        end
      end
      ST_RUN: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_en = (k != '0);
        k_next          = k + IDX_W'(1);
        pos_next        = (pos == LAST_IDX) ? '0 : pos + IDX_W'(1);
        if (k == LAST_IDX) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // add the last product
        mac_ctrl.acc_en = 1'b1;
        state_next      = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          load_out   = 1'b1;
          step_en    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      filtered_out <= acc;
    end
  end

endmodule

### rtl/flp3_checker.sv
// ----------------------------------------------------------------------------
// flp3_checker
// Port-level checks of the FIR filter, bound to the top level.
// ----------------------------------------------------------------------------
module flp3_checker
  import flp3_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [ACC_W-1:0] filtered_out
);

  localparam logic signed [ACC_W-1:0] OUT_MAX = 27'sd58523648;

  // busy straight after an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // no result appears in the cycle after an item is taken
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result too early after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(filtered_out))
    else $error("stalled result changed");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (filtered_out <= OUT_MAX) && (filtered_out >= -OUT_MAX))
    else $error("result out of range");

endmodule

bind fir_lowpass_17tap_three_band flp3_checker u_flp3_checker (.*);
